[rtl/twmf_pkg.sv]
// types and constants shared by the trimmed window mean filter
// no dependencies
package twmf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RING_DEPTH = 32;
   localparam int RING_AW    = 5;
   localparam int HALF_W     = 4;   // half-width 0..15
   localparam int CNT_W      = 5;   // window count 1..31
   localparam int SEEN_W     = 6;   // saturates at RING_DEPTH
   localparam int WIN_MAX    = 31;
   localparam int SUM_W      = 21;
   localparam int FRAC_W     = 7;
   localparam int DIVD_W     = SUM_W + 8;
   localparam int MEAN_W     = 24;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = 4;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 7;

   localparam logic [CSR_AW-1:0] CSR_WIN_SPAN      = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TRIM_CUTOFF   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_TRIM_FRACTION = 2'd2;

   localparam logic [CNT_W-1:0]  WIN_SPAN_RST      = 5'd5;
   localparam logic [CNT_W-1:0]  TRIM_CUTOFF_RST   = 5'd4;
   localparam logic [FRAC_W-1:0] TRIM_FRACTION_RST = 7'd26;

   typedef struct packed {
      logic [RING_AW-1:0] center;
      logic [HALF_W-1:0]  half;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic                en;
      logic [RING_AW-1:0]  addr;
      logic [SAMPLE_W-1:0] data;
   } ring_wr_type;

endpackage

[rtl/twmf_ram.sv]
// generic single write port ram with registered read
// no dependencies
module twmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/twmf_cmd_fifo.sv]
// queue of window commands between the front and the back
// depends on twmf_pkg
module twmf_cmd_fifo import twmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);
   cmd_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

[rtl/twmf_front.sv]
// front: accepts samples, writes the ring, queues one command per window
// depends on twmf_pkg
module twmf_front import twmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   input  logic [CNT_W-1:0]    win_span,
   input  logic                queue_empty,
   input  logic                queue_full,
   input  logic                back_loading,
   output ring_wr_type         ring_wr,
   output logic                push,
   output cmd_type             push_cmd
);
   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_EMIT = 2'b10
   } front_state_type;

   front_state_type     state_ff, state_in;
   logic [RING_AW-1:0]  wp_ff, wp_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [RING_AW-1:0]  addr_ff, addr_in;
   logic [RING_AW-1:0]  newest_ff, newest_in;
   logic [HALF_W-1:0]   w1_ff, w1_in;
   logic [HALF_W-1:0]   j_ff, j_in;
   logic                last_ff, last_in;

   logic                accept;
   logic [CNT_W:0]      wsum;
   logic [CNT_W-1:0]    w;
   logic [HALF_W-1:0]   w1;
   logic [SEEN_W-1:0]   seen_new;
   logic [RING_AW-1:0]  newest;
   logic [RING_AW-1:0]  c;
   logic [HALF_W-1:0]   h;

   always_comb begin
      wsum = {1'b0, win_span} + 1'b1;
      w    = wsum[CNT_W:1];
      if (w == '0) begin
         w = CNT_W'(1);
      end
      w1 = HALF_W'(w - 1'b1);
   end

   assign req_stall = !(state_ff == F_IDLE && queue_empty && !back_loading);
   assign accept    = req_valid && !req_stall;
   assign seen_new  = (seen_ff == SEEN_W'(RING_DEPTH)) ? seen_ff : seen_ff + 1'b1;
   assign newest    = RING_AW'(seen_new - 1'b1);

   assign ring_wr.en   = accept;
   assign ring_wr.addr = wp_ff;
   assign ring_wr.data = req_sample;

   // window of centre c is clamped by both stream ends
   always_comb begin
      c = newest_ff - RING_AW'(j_ff);
      h = w1_ff;
      if (c < RING_AW'(h)) begin
         h = HALF_W'(c);
      end
      if (j_ff < h) begin
         h = j_ff;
      end
   end

   assign push            = (state_ff == F_EMIT);
   assign push_cmd.center = addr_ff - RING_AW'(j_ff);
   assign push_cmd.half   = h;
   assign push_cmd.last   = last_ff && (j_ff == '0);

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      seen_in   = seen_ff;
      addr_in   = addr_ff;
      newest_in = newest_ff;
      w1_in     = w1_ff;
      j_in      = j_ff;
      last_in   = last_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               wp_in     = req_last ? '0 : wp_ff + 1'b1;
               seen_in   = req_last ? '0 : seen_new;
               addr_in   = wp_ff;
               newest_in = newest;
               w1_in     = w1;
               last_in   = req_last;
               if (req_last) begin
                  j_in     = (newest < RING_AW'(w1)) ? HALF_W'(newest) : w1;
                  state_in = F_EMIT;
               end else if (newest >= RING_AW'(w1)) begin
                  j_in     = w1;
                  state_in = F_EMIT;
               end
            end
         end
         F_EMIT: begin
            if (!queue_full) begin
               if (!last_ff || j_ff == '0) begin
                  state_in = F_IDLE;
               end else begin
                  j_in = j_ff - 1'b1;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      newest_ff <= newest_in;
      w1_ff     <= w1_in;
      j_ff      <= j_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff <= F_IDLE;
         wp_ff    <= '0;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         seen_ff  <= seen_in;
      end
   end
endmodule

[rtl/twmf_back.sv]
// back: loads one window, sorts it, sums the kept part and divides
// depends on twmf_pkg
module twmf_back import twmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                queue_empty,
   output logic                pop,
   input  logic [CNT_W-1:0]    trim_cutoff,
   input  logic [FRAC_W-1:0]   trim_fraction,
   output logic                rd_en,
   output logic [RING_AW-1:0]  rd_addr,
   input  logic [SAMPLE_W-1:0] rd_data,
   output logic                loading,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [MEAN_W-1:0]   rsp_mean_value,
   output logic [CNT_W-1:0]    rsp_kept_count,
   output logic                rsp_last_result
);
   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_LOAD = 6'b000010,
      B_SORT = 6'b000100,
      B_SUM  = 6'b001000,
      B_DIV  = 6'b010000,
      B_OUT  = 6'b100000
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [HALF_W-1:0]   t_ff, t_in;
   logic [CNT_W-1:0]    kept_ff, kept_in;
   logic [RING_AW-1:0]  base_ff, base_in;
   logic                last_ff, last_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] win_ff [WIN_MAX];
   logic [SAMPLE_W-1:0] win_in [WIN_MAX];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [CNT_W-1:0]    rkept_ff, rkept_in;
   logic                rlast_ff, rlast_in;

   logic [CNT_W-1:0]    n_cmd;
   logic [11:0]         prod;
   logic [HALF_W-1:0]   t_cmd;
   logic [CNT_W:0]      trial;
   logic                qbit;
   logic                out_free;
   logic                in_kept;

   assign pop     = (state_ff == B_IDLE) && !queue_empty;
   assign loading = (state_ff == B_LOAD);
   assign rd_en   = loading && (cnt_ff < n_ff);
   assign rd_addr = base_ff + cnt_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      n_cmd = {cmd.half, 1'b1};
      prod  = 12'(trim_fraction) * 12'(n_cmd);
      t_cmd = (n_cmd > trim_cutoff) ? prod[11:8] : '0;
   end

   assign in_kept = (cnt_ff >= CNT_W'(t_ff)) && ((cnt_ff - CNT_W'(t_ff)) < kept_ff);
   assign trial   = {rem_ff, quo_ff[DIVD_W-1]};
   assign qbit    = (trial >= {1'b0, kept_ff});

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      kept_in      = kept_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mean_in      = mean_ff;
      rkept_in     = rkept_ff;
      rlast_in     = rlast_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               n_in    = n_cmd;
               t_in    = t_cmd;
               kept_in = n_cmd - CNT_W'({t_cmd, 1'b0});
               base_in = cmd.center - RING_AW'(cmd.half);
               last_in = cmd.last;
               cnt_in  = '0;
               sum_in  = '0;
               // unused slots hold the largest value and sort to the top
               for (int i = 0; i < WIN_MAX; i++) begin
                  win_in[i] = '1;
               end
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            if (cnt_ff != '0) begin
               for (int i = 0; i < WIN_MAX - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[WIN_MAX-1] = rd_data;
            end
            if (cnt_ff == n_ff) begin
               cnt_in   = '0;
               state_in = B_SORT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_SORT: begin
            // odd-even transposition, one pass per cycle
            for (int i = 0; i < WIN_MAX - 1; i++) begin
               if ((i % 2) == int'(cnt_ff[0]) && win_ff[i] > win_ff[i+1]) begin
                  win_in[i]   = win_ff[i+1];
                  win_in[i+1] = win_ff[i];
               end
            end
            if (cnt_ff == CNT_W'(WIN_MAX - 1)) begin
               cnt_in   = '0;
               state_in = B_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_SUM: begin
            if (in_kept) begin
               sum_in = sum_ff + SUM_W'(win_ff[0]);
            end
            for (int i = 0; i < WIN_MAX - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            if (cnt_ff == n_ff - 1'b1) begin
               quo_in   = {sum_in, 8'd0};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = B_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_DIV: begin
            rem_in = qbit ? CNT_W'(trial - {1'b0, kept_ff}) : CNT_W'(trial);
            quo_in = {quo_ff[DIVD_W-2:0], qbit};
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               state_in = B_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mean_in      = (quo_ff[DIVD_W-1:MEAN_W] != '0) ? '1 : quo_ff[MEAN_W-1:0];
               rkept_in     = kept_ff;
               rlast_in     = last_ff;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      t_ff     <= t_in;
      kept_ff  <= kept_in;
      base_ff  <= base_in;
      last_ff  <= last_in;
      sum_ff   <= sum_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      win_ff   <= win_in;
      mean_ff  <= mean_in;
      rkept_ff <= rkept_in;
      rlast_ff <= rlast_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_value  = mean_ff;
   assign rsp_kept_count  = rkept_ff;
   assign rsp_last_result = rlast_ff;
endmodule

[rtl/trimmed_window_mean_filter.sv]
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_sample, req_last
// rsp       out  rsp_valid/rsp_stall  rsp_mean_value, rsp_kept_count, rsp_last_result
// csr       in   csr_valid/csr_ready  csr_index, csr_data
//
// each result for a window of n samples passes through the ring load, 31 sort passes,
// n sum steps and 29 divider steps in the back unit
// a sample is taken only if front idle, command queue empty and ring not being read
// a last sample queues up to 16 commands; the output register frees the back unit early
// reset is synchronous; registers return to 5, 4 and 26
// top level: config registers, sample ring, front, command queue and back
// depends on twmf_pkg, twmf_ram, twmf_cmd_fifo, twmf_front, twmf_back
module trimmed_window_mean_filter import twmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [MEAN_W-1:0]   rsp_mean_value,
   output logic [CNT_W-1:0]    rsp_kept_count,
   output logic                rsp_last_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_data
);
   logic [CNT_W-1:0]    win_span_ff, trim_cutoff_ff;
   logic [FRAC_W-1:0]   trim_fraction_ff;

   ring_wr_type         ring_wr;
   logic                rd_en;
   logic [RING_AW-1:0]  rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic                push, pop, q_empty, q_full, back_loading;
   cmd_type             push_cmd, head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_span_ff      <= WIN_SPAN_RST;
         trim_cutoff_ff   <= TRIM_CUTOFF_RST;
         trim_fraction_ff <= TRIM_FRACTION_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WIN_SPAN) begin
            win_span_ff <= csr_data[CNT_W-1:0];
         end
         if (csr_index == CSR_TRIM_CUTOFF) begin
            trim_cutoff_ff <= csr_data[CNT_W-1:0];
         end
         if (csr_index == CSR_TRIM_FRACTION) begin
            trim_fraction_ff <= csr_data[FRAC_W-1:0];
         end
      end
   end

   twmf_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr.en),
      .wr_addr (ring_wr.addr),
      .wr_data (ring_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   twmf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_last     (req_last),
      .win_span     (win_span_ff),
      .queue_empty  (q_empty),
      .queue_full   (q_full),
      .back_loading (back_loading),
      .ring_wr      (ring_wr),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   twmf_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   twmf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (head_cmd),
      .queue_empty     (q_empty),
      .pop             (pop),
      .trim_cutoff     (trim_cutoff_ff),
      .trim_fraction   (trim_fraction_ff),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .loading         (back_loading),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_kept_count  (rsp_kept_count),
      .rsp_last_result (rsp_last_result)
   );
endmodule
